### rtl/core/rc4_pkg.sv
// Shared constants, command codes and control structs for the RC4 cipher unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rc4_pkg;

    localparam int PERM_SIZE     = 256;
    localparam int IDX_W         = $clog2(PERM_SIZE);
    localparam int BYTE_W        = 8;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_WORD_W    = 64;
    localparam int BYTES_PER_WORD = KEY_WORD_W / BYTE_W;
    localparam int BYTE_SEL_W    = $clog2(BYTES_PER_WORD);
    localparam int KEY_WORDS     = MAX_KEY_BYTES / BYTES_PER_WORD;
    localparam int WORD_SEL_W    = $clog2(KEY_WORDS);
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_LEN_RESET = 16;
    localparam int CFG_IDX_W     = 3;

    // Input word operations.
    localparam logic OP_KEY_SCHEDULE = 1'b0;
    localparam logic OP_CRYPT        = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

    // Datapath step codes issued by the controller.
    typedef logic [3:0] dp_op_t;
    localparam dp_op_t DP_NOP    = 4'd0;
    localparam dp_op_t DP_FILL   = 4'd1;
    localparam dp_op_t DP_K_RD_N = 4'd2;
    localparam dp_op_t DP_K_RD_J = 4'd3;
    localparam dp_op_t DP_K_WR_N = 4'd4;
    localparam dp_op_t DP_K_WR_J = 4'd5;
    localparam dp_op_t DP_P_RD_I = 4'd6;
    localparam dp_op_t DP_P_RD_J = 4'd7;
    localparam dp_op_t DP_P_WR_I = 4'd8;
    localparam dp_op_t DP_P_WR_J = 4'd9;
    localparam dp_op_t DP_PASS   = 4'd10;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   load_out;
    } rc4_cmd_t;

    typedef struct packed {
        logic keyed;
        logic n_last;
        logic out_free;
    } rc4_status_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [KEY_WORD_W-1:0] data;
    } rc4_cfg_wr_t;

endpackage

### rtl/core/rc4_channels.sv
// Valid/ready channel interfaces for the RC4 cipher unit: input words,
// result words and configuration writes. Depends on rc4_pkg.
interface rc4_cmd_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] data_in;
    logic              end_of_message;

    modport source (output valid, operation, data_in, end_of_message, input ready);
    modport sink   (input valid, operation, data_in, end_of_message, output ready);
endinterface

interface rc4_res_if import rc4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              last;
    logic              not_keyed;

    modport source (output valid, data_out, last, not_keyed, input ready);
    modport sink   (input valid, data_out, last, not_keyed, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [KEY_WORD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rc4_ctrl.sv
// Sequencing state machine of the RC4 cipher unit: fill, key schedule and
// output steps. Depends on rc4_pkg; drives rc4_dp through rc4_cmd_t.
module rc4_ctrl import rc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_operation,
    output logic        in_ready,
    input  rc4_status_t status,
    output rc4_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_K_RD_N = 4'd2;
    localparam logic [3:0] S_K_RD_J = 4'd3;
    localparam logic [3:0] S_K_WR_N = 4'd4;
    localparam logic [3:0] S_K_WR_J = 4'd5;
    localparam logic [3:0] S_P_RD_I = 4'd6;
    localparam logic [3:0] S_P_RD_J = 4'd7;
    localparam logic [3:0] S_P_WR_I = 4'd8;
    localparam logic [3:0] S_P_WR_J = 4'd9;
    localparam logic [3:0] S_PASS   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_operation == OP_KEY_SCHEDULE)
                        state_next = S_FILL;
                    else if (status.keyed)
                        state_next = S_P_RD_I;
                    else
                        state_next = S_PASS;
                end
            end
            S_FILL:
            begin
                cmd.op = DP_FILL;
                if (status.n_last)
                    state_next = S_K_RD_N;
            end
            S_K_RD_N:
            begin
                cmd.op     = DP_K_RD_N;
                state_next = S_K_RD_J;
            end
            S_K_RD_J:
            begin
                cmd.op     = DP_K_RD_J;
                state_next = S_K_WR_N;
            end
            S_K_WR_N:
            begin
                cmd.op     = DP_K_WR_N;
                state_next = S_K_WR_J;
            end
            S_K_WR_J:
            begin
                cmd.op     = DP_K_WR_J;
                state_next = status.n_last ? S_IDLE : S_K_RD_N;
            end
            S_P_RD_I:
            begin
                cmd.op     = DP_P_RD_I;
                state_next = S_P_RD_J;
            end
            S_P_RD_J:
            begin
                cmd.op     = DP_P_RD_J;
                state_next = S_P_WR_I;
            end
            S_P_WR_I:
            begin
                cmd.op     = DP_P_WR_I;
                state_next = S_P_WR_J;
            end
            S_P_WR_J:
            begin
                // The second swap write repeats harmlessly while the result waits.
                cmd.op       = DP_P_WR_J;
                cmd.load_out = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            S_PASS:
            begin
                cmd.op       = DP_PASS;
                cmd.load_out = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/rc4_dp.sv
// Datapath of the RC4 cipher unit: key registers, permutation memory, indices,
// swap registers and the result register. Depends on rc4_pkg; driven by rc4_ctrl.
module rc4_dp import rc4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_cmd_t          cmd,
    output rc4_status_t       status,
    input  rc4_cfg_wr_t       cfg_wr,
    input  logic [BYTE_W-1:0] in_data,
    input  logic              in_eom,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_data,
    output logic              out_last,
    output logic              out_not_keyed
);

    logic [BYTE_W-1:0] perm_mem [PERM_SIZE];
    logic [BYTE_W-1:0] rdata_reg;

    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic [KEY_WORD_W-1:0] key_word_reg [KEY_WORDS];

    logic              keyed_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  n_reg;
    logic [IDX_W-1:0]  kj_reg;
    logic [KEY_IDX_W-1:0] kidx_reg;
    logic              out_valid_reg;

    logic [BYTE_W-1:0] si_reg;
    logic [BYTE_W-1:0] sj_reg;
    logic [IDX_W-1:0]  ka_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              eom_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_not_keyed_reg;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [BYTE_W-1:0]    wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
    logic [KEY_LEN_W-1:0] len_eff;
    logic [KEY_LEN_W-1:0] kidx_inc;
    logic [KEY_IDX_W-1:0] kidx_next;
    logic [BYTE_W-1:0]    key_byte;
    logic [IDX_W-1:0]     kj_new;
    logic [IDX_W-1:0]     j_new;
    logic [IDX_W-1:0]     ks_addr;
    logic [BYTE_W-1:0]    keystream;
    logic                 n_last;

    // A zero key length counts as one byte; longer keys saturate at the key store size.
    always_comb
    begin
        if (key_length_reg == '0)
            len_eff = KEY_LEN_W'(1);
        else if (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES))
            len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        else
            len_eff = key_length_reg;
    end

    assign kidx_inc  = {1'b0, kidx_reg} + KEY_LEN_W'(1);
    assign kidx_next = (kidx_inc == len_eff) ? '0 : kidx_inc[KEY_IDX_W-1:0];
    assign key_byte  = key_word_reg[kidx_reg[KEY_IDX_W-1:BYTE_SEL_W]]
                       [{kidx_reg[BYTE_SEL_W-1:0], 3'b000} +: BYTE_W];
    assign kj_new    = kj_reg + rdata_reg + key_byte;
    assign j_new     = j_reg + rdata_reg;
    assign ks_addr   = si_reg + rdata_reg;
    assign n_last    = (n_reg == '1);

    // After the swap S[j] holds the old S[i] and S[i] the old S[j]; the
    // keystream read was issued alongside the first swap write, before either write landed.
    always_comb
    begin
        if (ka_reg == j_reg)
            keystream = si_reg;
        else if (ka_reg == i_reg)
            keystream = sj_reg;
        else
            keystream = rdata_reg;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = n_reg;
        wdata = rdata_reg;
        re    = 1'b0;
        raddr = n_reg;
        unique case (cmd.op)
            DP_NOP, DP_PASS:
            begin
            end
            DP_FILL:
            begin
                we    = 1'b1;
                wdata = n_reg;
            end
            DP_K_RD_N:
            begin
                re = 1'b1;
            end
            DP_K_RD_J:
            begin
                re    = 1'b1;
                raddr = kj_new;
            end
            DP_K_WR_N:
            begin
                we = 1'b1;
            end
            DP_K_WR_J:
            begin
                we    = 1'b1;
                waddr = kj_reg;
                wdata = si_reg;
            end
            DP_P_RD_I:
            begin
                re    = 1'b1;
                raddr = i_reg + IDX_W'(1);
            end
            DP_P_RD_J:
            begin
                re    = 1'b1;
                raddr = j_new;
            end
            DP_P_WR_I:
            begin
                we    = 1'b1;
                waddr = i_reg;
                re    = 1'b1;
                raddr = ks_addr;
            end
            DP_P_WR_J:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = si_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            perm_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= perm_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_W'(KEY_LEN_RESET);
            for (int w = 0; w < KEY_WORDS; w++)
                key_word_reg[w] <= '0;
        end
        else if (cfg_wr.we)
        begin
            unique case (cfg_wr.index)
                REG_KEY_LENGTH: key_length_reg  <= cfg_wr.data[KEY_LEN_W-1:0];
                REG_KEY_WORD_0: key_word_reg[0] <= cfg_wr.data;
                REG_KEY_WORD_1: key_word_reg[1] <= cfg_wr.data;
                REG_KEY_WORD_2: key_word_reg[2] <= cfg_wr.data;
                REG_KEY_WORD_3: key_word_reg[3] <= cfg_wr.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kj_reg        <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                n_reg    <= '0;
                kj_reg   <= '0;
                kidx_reg <= '0;
            end
            unique case (cmd.op)
                DP_FILL:
                begin
                    n_reg <= n_reg + IDX_W'(1);
                end
                DP_K_RD_J:
                begin
                    kj_reg <= kj_new;
                end
                DP_K_WR_J:
                begin
                    n_reg    <= n_reg + IDX_W'(1);
                    kidx_reg <= kidx_next;
                    if (n_last)
                    begin
                        keyed_reg <= 1'b1;
                        i_reg     <= '0;
                        j_reg     <= '0;
                    end
                end
                DP_P_RD_I:
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
                DP_P_RD_J:
                begin
                    j_reg <= j_new;
                end
                default:
                begin
                end
            endcase
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg <= in_data;
            eom_reg  <= in_eom;
        end
        if (cmd.op == DP_K_RD_J || cmd.op == DP_P_RD_J)
            si_reg <= rdata_reg;
        if (cmd.op == DP_P_WR_I)
        begin
            sj_reg <= rdata_reg;
            ka_reg <= ks_addr;
        end
        if (cmd.load_out)
        begin
            out_last_reg <= eom_reg;
            if (cmd.op == DP_PASS)
            begin
                out_data_reg      <= data_reg;
                out_not_keyed_reg <= 1'b1;
            end
            else
            begin
                out_data_reg      <= data_reg ^ keystream;
                out_not_keyed_reg <= 1'b0;
            end
        end
    end

    assign status.keyed    = keyed_reg;
    assign status.n_last   = n_last;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_last      = out_last_reg;
    assign out_not_keyed = out_not_keyed_reg;

endmodule

### rtl/core/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit: input, result and configuration channels.
// cfg writes the key length (index 0) and the four 64-bit key words (indexes 1
// to 4); it is always ready and should be written only while the unit is idle.
// Writes to other indexes are ignored.
// A cmd word with operation 0 runs the key schedule: it loads the identity
// permutation, then runs 256 swap steps, and only after them is the next cmd
// word taken; there is no result word.
// A cmd word with operation 1 crypts one byte. With a key in place the unit
// reads S[i] and S[j], writes S[i] while issuing the keystream read, then
// writes S[j] and loads the result word, and only then takes the next cmd word;
// the reads of S[i] and S[j], the two swap writes and the keystream read share
// the single read port and the single write port of the permutation memory.
// Before any key schedule the byte goes through unchanged with not_keyed set,
// and the next such word is taken only after its result word is loaded.
// The last flag is a copy of end_of_message.
// Reset clears the indices, the keyed flag and the result valid flag, sets the
// key length to 16 with all key words zero; the permutation is first written by
// a key schedule.
// While res.ready is low a result word waits in the output register; the unit
// still takes the next cmd word but holds before loading its result until then.
module rc4_stream_cipher_unit import rc4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rc4_cmd_if.sink   cmd,
    rc4_res_if.source res,
    rc4_cfg_if.sink   cfg
);

    rc4_cmd_t    dp_cmd;
    rc4_status_t dp_status;
    rc4_cfg_wr_t cfg_wr;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.we    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    rc4_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd.valid),
        .in_operation (cmd.operation),
        .in_ready     (cmd.ready),
        .status       (dp_status),
        .cmd          (dp_cmd)
    );

    rc4_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .cfg_wr        (cfg_wr),
        .in_data       (cmd.data_in),
        .in_eom        (cmd.end_of_message),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .out_data      (res.data_out),
        .out_last      (res.last),
        .out_not_keyed (res.not_keyed)
    );

endmodule
